/* hw/rtl/nprr_pkg.sv */
// shared constants and types for the nsh path rule rewrite block
`timescale 1ns / 1ps

package nprr_pkg;

  localparam int RULE_SLOTS = 16;

  localparam int PATH_W = 24;
  localparam int SI_W   = 8;
  localparam int GATE_W = 13;
  localparam int STAT_W = 2;

  // item commands
  localparam logic CMD_CLASSIFY = 1'b0;
  localparam logic CMD_ADD      = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_PASS  = 2'd0;
  localparam logic [STAT_W-1:0] ST_MATCH = 2'd1;
  localparam logic [STAT_W-1:0] ST_ADDED = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [PATH_W-1:0] path_index;
    logic [SI_W-1:0]   service_index;
  } rule_key_t;

  typedef struct packed {
    logic [PATH_W-1:0] replace_path_index;
    logic [SI_W-1:0]   replace_service_index;
    logic [GATE_W-1:0] gate_choice;
  } rule_action_t;

  // item as it travels down the cell chain
  // for a classify, act carries the result so far; for an add, the new rule
  // done: classify has hit a rule, or add has found its slot
  typedef struct packed {
    logic         valid;
    logic         command;
    rule_key_t    key;
    rule_action_t act;
    logic         done;
  } chain_item_t;

endpackage

/* hw/rtl/nprr_if.sv */
// valid/ready channel interfaces for packet items and result items
`timescale 1ns / 1ps

interface nprr_in_if;
  import nprr_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [PATH_W-1:0] path_index;
  logic [SI_W-1:0]   service_index;
  logic [PATH_W-1:0] replace_path_index;
  logic [SI_W-1:0]   replace_service_index;
  logic [GATE_W-1:0] gate_choice;

  modport source (
    output valid, command, path_index, service_index,
           replace_path_index, replace_service_index, gate_choice,
    input  ready
  );
  modport sink (
    input  valid, command, path_index, service_index,
           replace_path_index, replace_service_index, gate_choice,
    output ready
  );
endinterface

interface nprr_out_if;
  import nprr_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [PATH_W-1:0] out_path_index;
  logic [SI_W-1:0]   out_service_index;
  logic [GATE_W-1:0] out_gate;

  modport source (
    output valid, status, out_path_index, out_service_index, out_gate,
    input  ready
  );
  modport sink (
    input  valid, status, out_path_index, out_service_index, out_gate,
    output ready
  );
endinterface

/* hw/rtl/nprr_cell.sv */
// one rule slot of the chain: holds a rule, matches or claims the slot, passes the item on
`timescale 1ns / 1ps

module nprr_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  nprr_pkg::chain_item_t item_in,
  output nprr_pkg::chain_item_t item_out
);
  import nprr_pkg::*;

  logic         rule_valid_r;
  rule_key_t    rule_key_r;
  rule_action_t rule_act_r;
  chain_item_t  stage_r;
  chain_item_t  stage_nxt;
  logic         wr_rule;
  logic         key_hit;

  assign key_hit = rule_valid_r && (rule_key_r == item_in.key);

  always_comb begin
    stage_nxt = item_in;
    wr_rule   = 1'b0;
    if (item_in.valid && !item_in.done) begin
      if (item_in.command == CMD_ADD) begin
        // slots fill in order, so the first empty one is the next free slot
        if (!rule_valid_r) begin
          wr_rule        = 1'b1;
          stage_nxt.done = 1'b1;
        end
      end else if (key_hit) begin
        stage_nxt.act  = rule_act_r;
        stage_nxt.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_valid_r  <= 1'b0;
      stage_r.valid <= 1'b0;
    end else if (adv) begin
      stage_r <= stage_nxt;
      if (wr_rule) begin
        rule_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr_rule) begin
      rule_key_r <= item_in.key;
      rule_act_r <= item_in.act;
    end
  end

  assign item_out = stage_r;

endmodule

/* hw/rtl/nsh_path_rule_rewrite.sv */
// top level of the nsh service path match-action table
`timescale 1ns / 1ps

// usage
//   in_ch takes one item per handshake: command 1 adds a rule built from the
//   match key (path_index, service_index) and the action (replace pair and
//   gate_choice); command 0 classifies a packet header by that key
//   out_ch returns exactly one item per input item, in order: status, the
//   rewritten or unchanged pair and the gate (all zero for add items)
//   the rule table is a chain of RULE_SLOTS cells, one rule per cell; an item
//   moves one cell per cycle while the chain is not stalled, so an item fed in
//   now sees every rule added ahead of it, and the earliest matching rule wins
//   path: an item passes through all RULE_SLOTS cells of the chain and then
//   the output register before it appears on out_ch
//   throughput: one item per cycle when not stalled, each cell a different item
//   stall: when out_ch is not ready with a result waiting, the whole chain
//   holds and in_ready drops; input and output still overlap otherwise
//   reset: all rules are dropped (cell valid bits cleared), chain and output
//   empty; the table is usable on the first cycle after reset

module nsh_path_rule_rewrite (
  input  logic       clk,
  input  logic       rst_n,
  nprr_in_if.sink    in_ch,
  nprr_out_if.source out_ch
);
  import nprr_pkg::*;

  chain_item_t link [0:RULE_SLOTS];
  chain_item_t head;

  logic adv;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [PATH_W-1:0] out_path_r;
  logic [SI_W-1:0]   out_si_r;
  logic [GATE_W-1:0] out_gate_r;

  logic              last_is_add;
  logic [STAT_W-1:0] fin_status;

  // the chain moves as a whole whenever the output register can take an item
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // classify items start with the unchanged pair and gate 0 as their result
  always_comb begin
    head.valid       = in_ch.valid;
    head.command     = in_ch.command;
    head.key.path_index    = in_ch.path_index;
    head.key.service_index = in_ch.service_index;
    head.done        = 1'b0;
    if (in_ch.command == CMD_ADD) begin
      head.act.replace_path_index    = in_ch.replace_path_index;
      head.act.replace_service_index = in_ch.replace_service_index;
      head.act.gate_choice           = in_ch.gate_choice;
    end else begin
      head.act.replace_path_index    = in_ch.path_index;
      head.act.replace_service_index = in_ch.service_index;
      head.act.gate_choice           = '0;
    end
  end

  assign link[0] = head;

  genvar g;
  generate
    for (g = 0; g < RULE_SLOTS; g++) begin : g_cell
      nprr_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .item_in  (link[g]),
        .item_out (link[g+1])
      );
    end
  endgenerate

  // final status from command and whether a rule matched or a slot was found
  assign last_is_add = (link[RULE_SLOTS].command == CMD_ADD);

  always_comb begin
    case ({last_is_add, link[RULE_SLOTS].done})
      2'b00:   fin_status = ST_PASS;
      2'b01:   fin_status = ST_MATCH;
      2'b10:   fin_status = ST_FULL;
      2'b11:   fin_status = ST_ADDED;
      default: fin_status = ST_PASS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= link[RULE_SLOTS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= fin_status;
      if (last_is_add) begin
        out_path_r <= '0;
        out_si_r   <= '0;
        out_gate_r <= '0;
      end else begin
        out_path_r <= link[RULE_SLOTS].act.replace_path_index;
        out_si_r   <= link[RULE_SLOTS].act.replace_service_index;
        out_gate_r <= link[RULE_SLOTS].act.gate_choice;
      end
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.out_path_index    = out_path_r;
  assign out_ch.out_service_index = out_si_r;
  assign out_ch.out_gate          = out_gate_r;

endmodule

/* test/tb.sv */
// testbench for the nsh path rule rewrite table: scoreboard class, drivers and checks
`timescale 1ns / 1ps

module tb;
  import nprr_pkg::*;

  // block depth: one cell per rule slot plus the output register
  localparam int LATENCY    = RULE_SLOTS + 1;
  localparam int RAND_ITEMS = 1036;
  // tail of the run with no idling on either side
  localparam int CALM_ITEMS = 150;
  // pause until drained every this many random items
  localparam int DRAIN_EVERY = 300;
  localparam int LIMIT = 200000;

  // one input item as the sender sees it
  typedef struct packed {
    logic         command;
    rule_key_t    key;
    rule_action_t act;
  } table_item_t;

  // one result item
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PATH_W-1:0] path_index;
    logic [SI_W-1:0]   service_index;
    logic [GATE_W-1:0] gate;
  } header_result_t;

  // private copy of the rule table and the queue of results still owed
  class rule_table_sb;
    rule_key_t      keys[RULE_SLOTS];
    rule_action_t   acts[RULE_SLOTS];
    int unsigned    used = 0;
    header_result_t owed[$];
    int unsigned    failures = 0;

    function int unsigned pending();
      return owed.size();
    endfunction

    // work out what an accepted item must produce and queue it
    function void note_item(input table_item_t it);
      header_result_t r;
      logic           hit;
      r   = '0;
      hit = 1'b0;
      if (it.command == CMD_ADD) begin
        if (used < RULE_SLOTS) begin
          keys[used] = it.key;
          acts[used] = it.act;
          used++;
          r.status = ST_ADDED;
        end else begin
          r.status = ST_FULL;
        end
      end else begin
        // unmatched header passes through to gate 0
        r.status        = ST_PASS;
        r.path_index    = it.key.path_index;
        r.service_index = it.key.service_index;
        // earliest rule wins, so stop at the first hit
        for (int unsigned i = 0; i < used; i++) begin
          if (!hit && keys[i] == it.key) begin
            hit             = 1'b1;
            r.status        = ST_MATCH;
            r.path_index    = acts[i].replace_path_index;
            r.service_index = acts[i].replace_service_index;
            r.gate          = acts[i].gate_choice;
          end
        end
      end
      owed = {owed, r};
    endfunction

    function void check_result(input header_result_t got);
      header_result_t want;
      if (owed.size() == 0) begin
        $error("result with nothing owed: status %0d path %h si %h gate %h",
               got.status, got.path_index, got.service_index, got.gate);
        failures++;
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        failures++;
      end
      if (got.path_index !== want.path_index) begin
        $error("out_path_index: expected %h, actual %h", want.path_index, got.path_index);
        failures++;
      end
      if (got.service_index !== want.service_index) begin
        $error("out_service_index: expected %h, actual %h",
               want.service_index, got.service_index);
        failures++;
      end
      if (got.gate !== want.gate) begin
        $error("out_gate: expected %h, actual %h", want.gate, got.gate);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic calm;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;

  rule_table_sb sb = new;

  // every key ever offered in an add, dropped ones included
  rule_key_t key_pool[$];

  nprr_in_if  in_ch ();
  nprr_out_if out_ch ();

  nsh_path_rule_rewrite dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // result side: check on handshake, then decide ready for the next edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result({out_ch.status, out_ch.out_path_index,
                       out_ch.out_service_index, out_ch.out_gate});
    end
    if (stall_left != 0) begin
      // stall burst still running
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      // start a stall burst, its length drawn at random into stall_left
      stall_left   <= $urandom_range(0, 6);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic table_item_t make_item(input logic cmd,
                                            input logic [PATH_W-1:0] path,
                                            input logic [SI_W-1:0] si,
                                            input logic [PATH_W-1:0] rpath,
                                            input logic [SI_W-1:0] rsi,
                                            input logic [GATE_W-1:0] gate);
    table_item_t it;
    it.command                   = cmd;
    it.key.path_index            = path;
    it.key.service_index         = si;
    it.act.replace_path_index    = rpath;
    it.act.replace_service_index = rsi;
    it.act.gate_choice           = gate;
    return it;
  endfunction

  // random item: mostly headers aimed at known keys, some adds and near misses
  function automatic table_item_t random_item();
    table_item_t it;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    it = make_item($urandom_range(0, 1) ? CMD_ADD : CMD_CLASSIFY, PATH_W'($urandom),
                   SI_W'($urandom), PATH_W'($urandom), SI_W'($urandom),
                   GATE_W'($urandom));
    if (roll < 20) begin
      it.command = CMD_ADD;
      // a quarter of the adds repeat an earlier key
      if (key_pool.size() != 0 && $urandom_range(0, 3) == 0)
        it.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else begin
      it.command = CMD_CLASSIFY;
      if (key_pool.size() != 0 && roll < 75) begin
        it.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else if (key_pool.size() != 0 && roll < 90) begin
        // near miss: one key bit flipped
        it.key = rule_key_t'(key_pool[$urandom_range(0, key_pool.size() - 1)]
                             ^ (32'd1 << $urandom_range(0, 31)));
      end
    end
    return it;
  endfunction

  // present an item and hold it until the block takes it
  task automatic offer_item(input table_item_t it);
    in_ch.valid                 <= 1'b1;
    in_ch.command               <= it.command;
    in_ch.path_index            <= it.key.path_index;
    in_ch.service_index         <= it.key.service_index;
    in_ch.replace_path_index    <= it.act.replace_path_index;
    in_ch.replace_service_index <= it.act.replace_service_index;
    in_ch.gate_choice           <= it.act.gate_choice;
    do @(posedge clk); while (!in_ch.ready);
    if (it.command == CMD_ADD) key_pool = {key_pool, it.key};
    sb.note_item(it);
  endtask

  // drop valid with junk on the command and key fields, for the given gap
  task automatic idle_sender(input int unsigned n);
    in_ch.valid         <= 1'b0;
    in_ch.command       <= 1'($urandom);
    in_ch.path_index    <= PATH_W'($urandom);
    in_ch.service_index <= SI_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // random gap after an item, except in the calm tail
  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 9) == 0) idle_sender($urandom_range(1, 7));
  endtask

  // hold off until every owed result is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_directed();
    table_item_t plan[$];
    // empty table: both key extremes pass through
    plan = {plan, make_item(CMD_CLASSIFY, 24'h000000, 8'h00, 24'h000000, 8'h00, 13'h0000)};
    plan = {plan, make_item(CMD_CLASSIFY, 24'hFFFFFF, 8'hFF, 24'hFFFFFF, 8'hFF, 13'h1FFF)};
    // rules at the key and action extremes
    plan = {plan, make_item(CMD_ADD, 24'h000000, 8'h00, 24'hFFFFFF, 8'hFF, 13'h1FFF)};
    plan = {plan, make_item(CMD_ADD, 24'hFFFFFF, 8'hFF, 24'h000000, 8'h00, 13'h0000)};
    plan = {plan, make_item(CMD_CLASSIFY, 24'h000000, 8'h00, 24'h000000, 8'h00, 13'h0000)};
    // match with an all-zero action
    plan = {plan, make_item(CMD_CLASSIFY, 24'hFFFFFF, 8'hFF, 24'h000000, 8'h00, 13'h0000)};
    // duplicate key: only the first copy may ever apply
    plan = {plan, make_item(CMD_ADD, 24'h123456, 8'h07, 24'h654321, 8'h70, 13'h0AAA)};
    plan = {plan, make_item(CMD_ADD, 24'h123456, 8'h07, 24'h0ABCDE, 8'h33, 13'h1555)};
    plan = {plan, make_item(CMD_CLASSIFY, 24'h123456, 8'h07, 24'h000000, 8'h00, 13'h0000)};
    // service index off by one, replace fields must be ignored
    plan = {plan, make_item(CMD_CLASSIFY, 24'h123456, 8'h08, 24'hFFFFFF, 8'hFF, 13'h1FFF)};
    // path top bit off
    plan = {plan, make_item(CMD_CLASSIFY, 24'h923456, 8'h07, 24'h000000, 8'h00, 13'h0000)};
    // add followed at once by a header that hits it
    plan = {plan, make_item(CMD_ADD, 24'hA5A5A5, 8'h5A, 24'h5A5A5A, 8'hA5, 13'h0001)};
    plan = {plan, make_item(CMD_CLASSIFY, 24'hA5A5A5, 8'h5A, 24'h000000, 8'h00, 13'h0000)};
    // path of one rule with the service index of another
    plan = {plan, make_item(CMD_CLASSIFY, 24'h000000, 8'hFF, 24'h000000, 8'h00, 13'h0000)};
    foreach (plan[i]) begin
      offer_item(plan[i]);
      maybe_idle();
    end
  endtask

  initial begin
    clk                          = 1'b0;
    rst_n                        = 1'b0;
    calm                         = 1'b0;
    in_ch.valid                  = 1'b0;
    in_ch.command                = CMD_CLASSIFY;
    in_ch.path_index             = '0;
    in_ch.service_index          = '0;
    in_ch.replace_path_index     = '0;
    in_ch.replace_service_index  = '0;
    in_ch.gate_choice            = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_directed();
    // sender holds off until the pipe is empty
    wait_drained();

    // random part: the table fills early, later adds get dropped
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS - CALM_ITEMS) calm <= 1'b1;
      if (i != 0 && i % DRAIN_EVERY == 0) wait_drained();
      offer_item(random_item());
      maybe_idle();
    end
    in_ch.valid <= 1'b0;

    // wait for the tail, then a little longer to catch stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (3 * LATENCY) @(posedge clk);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
